FILE: rtl/lmb_pkg.sv
// shared types and constants of the local min/max window binarizer
`timescale 1ns / 1ps
`default_nettype none

package lmb_pkg;

  localparam int PIX_W      = 8;   // gray pixel
  localparam int COL_W      = 11;  // width register and column counters
  localparam int ROW_W      = 16;  // height register, row and pending counters
  localparam int LIM_W      = 8;   // contrast and mean limits
  localparam int ADDR_MAX_W = 11;  // bank address, enough for every legal build
  localparam int SLOT_MAX_W = 4;   // line slot index
  localparam int BANK_MAX_W = 4;   // column bank index
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 8;

  // one word from the front to the back: an optional line store write and an
  // optional window evaluation at the output position
  typedef struct packed {
    logic                  wr;
    logic                  em;
    logic [PIX_W-1:0]      wdata;
    logic [SLOT_MAX_W-1:0] wslot;
    logic [BANK_MAX_W-1:0] wbank;
    logic [ADDR_MAX_W-1:0] waddr;
    logic [SLOT_MAX_W-1:0] oslot;
    logic [BANK_MAX_W-1:0] obank;
    logic [ADDR_MAX_W-1:0] oaddr;
    logic                  inner;
    logic                  last;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/lmb_front.sv
// front end: raster position tracking, pending count and command build
`timescale 1ns / 1ps
`default_nettype none

module lmb_front
  import lmb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int WIN_W     = 5,
  parameter int WIN_H     = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             clr_pos_i,
  input  wire logic [COL_W-1:0] eff_w_i,
  input  wire logic [ROW_W-1:0] eff_h_i,
  input  wire logic             acc_i,
  input  wire logic             mode_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  output cmd_t                  cmd_o,
  output logic                  cmd_push_o
);

  localparam int SLOTS  = WIN_H + 1;
  localparam int HALF_W = WIN_W / 2;
  localparam int HALF_H = WIN_H / 2;
  localparam int BW     = $clog2(WIN_W);
  localparam int SW     = $clog2(SLOTS);
  localparam int BANK_D = (MAX_WIDTH + WIN_W - 1) / WIN_W;
  localparam int AW     = (BANK_D > 1) ? $clog2(BANK_D) : 1;

  localparam logic [BW-1:0] LAST_BANK  = BW'(WIN_W - 1);
  localparam logic [SW-1:0] LAST_SLOT  = SW'(SLOTS - 1);
  localparam logic          MODE_PIXEL = 1'b0;

  logic [COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [BW-1:0]    in_bank_r, in_bank_nxt, out_bank_r, out_bank_nxt;
  logic [AW-1:0]    in_addr_r, in_addr_nxt, out_addr_r, out_addr_nxt;
  logic [SW-1:0]    in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [ROW_W-1:0] pend_r, pend_nxt;

  logic [ROW_W-1:0] lag;
  logic             is_pix;
  logic             emit;
  logic             inner;
  logic             last;

  // results trail their pixel by half a window of rows plus half a window width of pixels
  assign lag    = ROW_W'(HALF_H) * ROW_W'(eff_w_i) + ROW_W'(HALF_W);
  assign is_pix = (mode_i == MODE_PIXEL);
  assign emit   = is_pix ? (pend_r >= lag) : (pend_r != '0);

  assign inner = (out_row_r >= ROW_W'(HALF_H)) &&
                 (({1'b0, out_row_r} + (ROW_W+1)'(HALF_H)) < {1'b0, eff_h_i}) &&
                 (out_col_r >= COL_W'(HALF_W)) &&
                 (({1'b0, out_col_r} + (COL_W+1)'(HALF_W)) < {1'b0, eff_w_i});
  assign last  = (out_row_r == eff_h_i - ROW_W'(1)) && (out_col_r == eff_w_i - COL_W'(1));

  always_comb begin
    cmd_o.wr    = is_pix;
    cmd_o.em    = emit;
    cmd_o.wdata = pixel_i;
    cmd_o.wslot = SLOT_MAX_W'(in_slot_r);
    cmd_o.wbank = BANK_MAX_W'(in_bank_r);
    cmd_o.waddr = ADDR_MAX_W'(in_addr_r);
    cmd_o.oslot = SLOT_MAX_W'(out_slot_r);
    cmd_o.obank = BANK_MAX_W'(out_bank_r);
    cmd_o.oaddr = ADDR_MAX_W'(out_addr_r);
    cmd_o.inner = inner;
    cmd_o.last  = last;
  end

  // a flush with nothing pending leaves no trace
  assign cmd_push_o = acc_i && (is_pix || (pend_r != '0));

  always_comb begin
    in_col_nxt   = in_col_r;
    in_bank_nxt  = in_bank_r;
    in_addr_nxt  = in_addr_r;
    in_slot_nxt  = in_slot_r;
    out_col_nxt  = out_col_r;
    out_bank_nxt = out_bank_r;
    out_addr_nxt = out_addr_r;
    out_slot_nxt = out_slot_r;
    out_row_nxt  = out_row_r;
    pend_nxt     = pend_r;

    if (acc_i && is_pix) begin
      if (in_col_r == eff_w_i - COL_W'(1)) begin
        in_col_nxt  = '0;
        in_bank_nxt = '0;
        in_addr_nxt = '0;
        in_slot_nxt = (in_slot_r == LAST_SLOT) ? '0 : in_slot_r + SW'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
        if (in_bank_r == LAST_BANK) begin
          in_bank_nxt = '0;
          in_addr_nxt = in_addr_r + AW'(1);
        end else begin
          in_bank_nxt = in_bank_r + BW'(1);
        end
      end
    end

    if (acc_i && emit) begin
      if (out_col_r == eff_w_i - COL_W'(1)) begin
        out_col_nxt  = '0;
        out_bank_nxt = '0;
        out_addr_nxt = '0;
        out_slot_nxt = (out_slot_r == LAST_SLOT) ? '0 : out_slot_r + SW'(1);
        out_row_nxt  = (out_row_r == eff_h_i - ROW_W'(1)) ? '0 : out_row_r + ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
        if (out_bank_r == LAST_BANK) begin
          out_bank_nxt = '0;
          out_addr_nxt = out_addr_r + AW'(1);
        end else begin
          out_bank_nxt = out_bank_r + BW'(1);
        end
      end
    end

    if (acc_i) begin
      priority if (is_pix && !emit) begin
        pend_nxt = pend_r + ROW_W'(1);
      end else if (!is_pix && emit) begin
        pend_nxt = pend_r - ROW_W'(1);
      end else begin
        pend_nxt = pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_pos_i) begin
      in_col_r   <= '0;
      in_bank_r  <= '0;
      in_addr_r  <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_bank_r <= '0;
      out_addr_r <= '0;
      out_slot_r <= '0;
      out_row_r  <= '0;
      pend_r     <= '0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_bank_r  <= in_bank_nxt;
      in_addr_r  <= in_addr_nxt;
      in_slot_r  <= in_slot_nxt;
      out_col_r  <= out_col_nxt;
      out_bank_r <= out_bank_nxt;
      out_addr_r <= out_addr_nxt;
      out_slot_r <= out_slot_nxt;
      out_row_r  <= out_row_nxt;
      pend_r     <= pend_nxt;
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= lag)
    else $error("pending count above the output lag");

  a_in_col: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r < eff_w_i)
    else $error("input column outside the row");

  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_col_r < eff_w_i) && (out_row_r < eff_h_i))
    else $error("output position outside the frame");

endmodule

`default_nettype wire

FILE: rtl/lmb_cmdq.sv
// short command queue between the front end and the window engine
`timescale 1ns / 1ps
`default_nettype none

module lmb_cmdq
  import lmb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  cmd_t      data_i,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int PW = $clog2(CMDQ_DEPTH);

  localparam logic [PW-1:0] LAST_IDX = PW'(CMDQ_DEPTH - 1);

  cmd_t             entries_r [CMDQ_DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [PW:0]      cnt_r;

  assign empty_o = (cnt_r == '0);
  assign full_o  = (cnt_r == (PW+1)'(CMDQ_DEPTH));
  assign data_o  = entries_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      entries_r[wptr_r] <= data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push_i) begin
        wptr_r <= (wptr_r == LAST_IDX) ? '0 : wptr_r + PW'(1);
      end
      if (pop_i) begin
        rptr_r <= (rptr_r == LAST_IDX) ? '0 : rptr_r + PW'(1);
      end
      priority if (push_i && !pop_i) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (!push_i && pop_i) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (!full_o || pop_i))
    else $error("command queue written while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !empty_o)
    else $error("command queue read while empty");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wptr_r == rptr_r))
    else $error("command queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: rtl/lmb_back.sv
// back end: banked line store, window min/max tree, decision and result queue
`timescale 1ns / 1ps
`default_nettype none

module lmb_back
  import lmb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int WIN_W     = 5,
  parameter int WIN_H     = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  output logic                  clearing_o,
  input  wire logic             q_empty_i,
  input  cmd_t                  q_head_i,
  output logic                  q_pop_o,
  input  wire logic             contrast_mode_i,
  input  wire logic [LIM_W-1:0] contrast_limit_i,
  input  wire logic [LIM_W-1:0] mean_limit_i,
  output logic                  out_empty_o,
  input  wire logic             out_pop_i,
  output logic                  out_bit_o,
  output logic                  out_last_o
);

  localparam int SLOTS  = WIN_H + 1;
  localparam int HALF_W = WIN_W / 2;
  localparam int HALF_H = WIN_H / 2;
  localparam int BW     = $clog2(WIN_W);
  localparam int SW     = $clog2(SLOTS);
  localparam int BANK_D = (MAX_WIDTH + WIN_W - 1) / WIN_W;
  localparam int AW     = (BANK_D > 1) ? $clog2(BANK_D) : 1;
  localparam int MEM_D  = 1 << AW;
  localparam int TW_L   = $clog2(WIN_W);
  localparam int TW_N   = 1 << TW_L;
  localparam int TS_N   = 1 << SW;
  localparam int QW     = $clog2(OUTQ_DEPTH);

  localparam logic [AW-1:0]   LAST_ADDR = AW'(MEM_D - 1);
  localparam logic [QW-1:0]   LAST_QIDX = QW'(OUTQ_DEPTH - 1);
  localparam logic [QW:0]     QFULL     = (QW+1)'(OUTQ_DEPTH);
  localparam logic [PIX_W:0]  SLOTS_X   = (PIX_W+1)'(SLOTS);

  // ---------------------------------------------------------------- clear pass
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_r <= 1'b0;
      end
    end
  end

  assign clearing_o = clr_r;

  // ---------------------------------------------------------------- issue
  logic [QW:0]    credit_r;
  logic           oq_pop;
  logic           pop;
  logic [AW-1:0]  raddr [WIN_W];
  logic [AW-1:0]  waddr_m;
  logic [PIX_W-1:0] wdata_m;
  logic           we [SLOTS][WIN_W];
  logic [WIN_W-1:0] fwd_nxt;
  logic [SW:0]    excl_sum;
  logic [SW-1:0]  excl;

  // an evaluation only goes once the result queue is sure to have room for it
  assign pop     = !clr_r && !q_empty_i && (!q_head_i.em || (credit_r != QFULL));
  assign q_pop_o = pop;

  // bank b holds columns c with c mod WIN_W == b; the window touches each bank once
  always_comb begin
    int d;
    d = 0;
    for (int b = 0; b < WIN_W; b++) begin
      d = b - int'(q_head_i.obank);
      if (d > WIN_W - 1 - HALF_W) begin
        raddr[b] = q_head_i.oaddr[AW-1:0] - AW'(1);
      end else if (d < -HALF_W) begin
        raddr[b] = q_head_i.oaddr[AW-1:0] + AW'(1);
      end else begin
        raddr[b] = q_head_i.oaddr[AW-1:0];
      end
    end
  end

  assign waddr_m = clr_r ? clr_addr_r : q_head_i.waddr[AW-1:0];
  assign wdata_m = clr_r ? '0 : q_head_i.wdata;

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      for (int b = 0; b < WIN_W; b++) begin
        we[s][b] = clr_r || (pop && q_head_i.wr &&
                             (q_head_i.wslot == SLOT_MAX_W'(s)) &&
                             (q_head_i.wbank == BANK_MAX_W'(b)));
      end
    end
    // the word's own write must be seen by its own window read
    for (int b = 0; b < WIN_W; b++) begin
      fwd_nxt[b] = q_head_i.wr && (q_head_i.wbank == BANK_MAX_W'(b)) &&
                   (raddr[b] == q_head_i.waddr[AW-1:0]);
    end
  end

  // the one slot the window leaves out
  assign excl_sum = {1'b0, q_head_i.oslot[SW-1:0]} + (SW+1)'(WIN_H - HALF_H);
  assign excl     = (excl_sum >= SLOTS_X[SW:0]) ? SW'(excl_sum - SLOTS_X[SW:0])
                                                : excl_sum[SW-1:0];

  // ---------------------------------------------------------------- line store
  logic [PIX_W-1:0] rd_val [SLOTS][WIN_W];

  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    for (genvar b = 0; b < WIN_W; b++) begin : g_bank
      logic [PIX_W-1:0] ram [MEM_D];
      logic [PIX_W-1:0] rdata_r;

      always_ff @(posedge clk) begin
        if (we[s][b]) begin
          ram[waddr_m] <= wdata_m;
        end
        rdata_r <= ram[raddr[b]];
      end

      assign rd_val[s][b] = rdata_r;
    end
  end

  // ---------------------------------------------------------------- stage a
  logic             a_vld_r;
  logic [WIN_W-1:0] a_fwd_r;
  logic [SW-1:0]    a_wslot_r;
  logic [PIX_W-1:0] a_wdata_r;
  logic [SW-1:0]    a_oslot_r;
  logic [BW-1:0]    a_obank_r;
  logic [SW-1:0]    a_excl_r;
  logic             a_inner_r;
  logic             a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= pop && q_head_i.em;
    end
    a_fwd_r   <= fwd_nxt;
    a_wslot_r <= q_head_i.wslot[SW-1:0];
    a_wdata_r <= q_head_i.wdata;
    a_oslot_r <= q_head_i.oslot[SW-1:0];
    a_obank_r <= q_head_i.obank[BW-1:0];
    a_excl_r  <= excl;
    a_inner_r <= q_head_i.inner;
    a_last_r  <= q_head_i.last;
  end

  // ---------------------------------------------------------------- stage b: row trees
  logic [PIX_W-1:0] val [SLOTS][WIN_W];
  logic [PIX_W-1:0] row_max [SLOTS];
  logic [PIX_W-1:0] row_min [SLOTS];
  logic [PIX_W-1:0] own;

  always_comb begin
    logic [PIX_W-1:0] tmx [TW_N];
    logic [PIX_W-1:0] tmn [TW_N];
    for (int s = 0; s < SLOTS; s++) begin
      for (int b = 0; b < WIN_W; b++) begin
        val[s][b] = (a_fwd_r[b] && (a_wslot_r == SW'(s))) ? a_wdata_r : rd_val[s][b];
      end
    end
    for (int s = 0; s < SLOTS; s++) begin
      for (int i = 0; i < TW_N; i++) begin
        tmx[i] = '0;
        tmn[i] = '1;
      end
      for (int i = 0; i < WIN_W; i++) begin
        tmx[i] = val[s][i];
        tmn[i] = val[s][i];
      end
      for (int l = 0; l < TW_L; l++) begin
        for (int i = 0; i < (TW_N >> (l + 1)); i++) begin
          tmx[i] = (tmx[2*i] > tmx[2*i+1]) ? tmx[2*i] : tmx[2*i+1];
          tmn[i] = (tmn[2*i] < tmn[2*i+1]) ? tmn[2*i] : tmn[2*i+1];
        end
      end
      row_max[s] = tmx[0];
      row_min[s] = tmn[0];
    end
    own = val[a_oslot_r][a_obank_r];
  end

  logic             b_vld_r;
  logic [PIX_W-1:0] b_rmax_r [SLOTS];
  logic [PIX_W-1:0] b_rmin_r [SLOTS];
  logic [PIX_W-1:0] b_own_r;
  logic [SW-1:0]    b_excl_r;
  logic             b_inner_r;
  logic             b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
    b_rmax_r  <= row_max;
    b_rmin_r  <= row_min;
    b_own_r   <= own;
    b_excl_r  <= a_excl_r;
    b_inner_r <= a_inner_r;
    b_last_r  <= a_last_r;
  end

  // ---------------------------------------------------------------- stage c: column tree
  logic [PIX_W-1:0] win_max;
  logic [PIX_W-1:0] win_min;

  always_comb begin
    logic [PIX_W-1:0] smx [TS_N];
    logic [PIX_W-1:0] smn [TS_N];
    for (int i = 0; i < TS_N; i++) begin
      smx[i] = '0;
      smn[i] = '1;
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (b_excl_r != SW'(s)) begin
        smx[s] = b_rmax_r[s];
        smn[s] = b_rmin_r[s];
      end
    end
    for (int l = 0; l < SW; l++) begin
      for (int i = 0; i < (TS_N >> (l + 1)); i++) begin
        smx[i] = (smx[2*i] > smx[2*i+1]) ? smx[2*i] : smx[2*i+1];
        smn[i] = (smn[2*i] < smn[2*i+1]) ? smn[2*i] : smn[2*i+1];
      end
    end
    win_max = smx[0];
    win_min = smn[0];
  end

  logic             c_vld_r;
  logic [PIX_W-1:0] c_max_r;
  logic [PIX_W-1:0] c_min_r;
  logic [PIX_W-1:0] c_own_r;
  logic             c_inner_r;
  logic             c_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
    c_max_r   <= win_max;
    c_min_r   <= win_min;
    c_own_r   <= b_own_r;
    c_inner_r <= b_inner_r;
    c_last_r  <= b_last_r;
  end

  // ---------------------------------------------------------------- decision
  logic [PIX_W:0]   mid_sum;
  logic [PIX_W-1:0] mid;
  logic [PIX_W-1:0] con;
  logic             bit_d;

  // border pixels see midpoint and contrast of zero
  assign mid_sum = {1'b0, c_max_r} + {1'b0, c_min_r};
  assign mid     = c_inner_r ? mid_sum[PIX_W:1] : '0;
  assign con     = c_inner_r ? (c_max_r - c_min_r) : '0;

  always_comb begin
    priority if (!contrast_mode_i) begin
      bit_d = (c_own_r > mid);
    end else if (con > contrast_limit_i) begin
      bit_d = 1'b1;
    end else if (con < contrast_limit_i) begin
      bit_d = (mid > mean_limit_i);
    end else begin
      bit_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- result queue
  logic          oq_bit_r  [OUTQ_DEPTH];
  logic          oq_last_r [OUTQ_DEPTH];
  logic [QW-1:0] oq_wptr_r, oq_rptr_r;
  logic [QW:0]   oq_cnt_r;

  assign out_empty_o = (oq_cnt_r == '0);
  assign oq_pop      = out_pop_i && !out_empty_o;
  assign out_bit_o   = oq_bit_r[oq_rptr_r];
  assign out_last_o  = oq_last_r[oq_rptr_r];

  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      oq_bit_r[oq_wptr_r]  <= bit_d;
      oq_last_r[oq_wptr_r] <= c_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
      credit_r  <= '0;
    end else begin
      if (c_vld_r) begin
        oq_wptr_r <= (oq_wptr_r == LAST_QIDX) ? '0 : oq_wptr_r + QW'(1);
      end
      if (oq_pop) begin
        oq_rptr_r <= (oq_rptr_r == LAST_QIDX) ? '0 : oq_rptr_r + QW'(1);
      end
      priority if (c_vld_r && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + (QW+1)'(1);
      end else if (!c_vld_r && oq_pop) begin
        oq_cnt_r <= oq_cnt_r - (QW+1)'(1);
      end else begin
        oq_cnt_r <= oq_cnt_r;
      end
      // credits cover words in the pipe and words already queued
      priority if ((pop && q_head_i.em) && !oq_pop) begin
        credit_r <= credit_r + (QW+1)'(1);
      end else if (!(pop && q_head_i.em) && oq_pop) begin
        credit_r <= credit_r - (QW+1)'(1);
      end else begin
        credit_r <= credit_r;
      end
    end
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= QFULL)
    else $error("result credits above queue depth");

  a_credit_track: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r == ((QW+1)'($countones({a_vld_r, b_vld_r, c_vld_r})) + oq_cnt_r))
    else $error("result credits out of step with pipe and queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    c_vld_r |-> ((oq_cnt_r != QFULL) || oq_pop))
    else $error("result queue written while full");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !(a_vld_r || b_vld_r || c_vld_r))
    else $error("window evaluation during line store clear");

endmodule

`default_nettype wire

FILE: rtl/local_minmax_window_binarizer.sv
// Local min/max window binarizer: streams 8-bit gray pixels to one-bit results.
// Input queue side: push/full with in_mode (0 pixel, 1 flush) and in_pixel.
// Result queue side: empty/pop with out_binary_pixel and out_frame_last.
// Configuration: APB-style port, registers at byte addresses 0, 4, 8, 12, 16:
// width, height, contrast mode, contrast limit, mean limit. Write the size
// registers only while idle; doing so drops pending results and restarts the
// raster position.
// A pixel's result is released after (WIN_H/2)*width + WIN_W/2 further pixels,
// or earlier by flush words. Once released it is registered in turn by the
// command queue, line store read, row trees and column tree before it enters
// the result queue. Throughput is one word per clock on both sides unless
// held off by full or empty; each line store bank has one write and one read
// port, used once per word.
// After reset the line store is cleared over all 2**ceil(log2(ceil(MAX_WIDTH/WIN_W)))
// addresses of each bank (256 for the default build); full stays high meanwhile.
// A stalled result side fills an 8-word result queue and then a 4-word command
// queue, after which full rises; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module local_minmax_window_binarizer
  import lmb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int WIN_W     = 5,
  parameter int WIN_H     = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             in_mode,
  input  wire logic [PIX_W-1:0] in_pixel,
  output logic                  empty,
  input  wire logic             pop,
  output logic                  out_binary_pixel,
  output logic                  out_frame_last,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int W_CAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MODE   = 3'd2;
  localparam logic [2:0] REG_CLIM   = 3'd3;
  localparam logic [2:0] REG_MLIM   = 3'd4;

  logic [COL_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;
  logic             cmode_r;
  logic [LIM_W-1:0] clim_r;
  logic [LIM_W-1:0] mlim_r;

  logic             cfg_wr;
  logic [2:0]       reg_idx;
  logic             size_wr;
  logic [COL_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];
  assign size_wr = cfg_wr && ((reg_idx == REG_WIDTH) || (reg_idx == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= COL_W'(640);
      height_r <= ROW_W'(480);
      cmode_r  <= 1'b0;
      clim_r   <= LIM_W'(15);
      mlim_r   <= LIM_W'(127);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  width_r  <= pwdata[COL_W-1:0];
        REG_HEIGHT: height_r <= pwdata[ROW_W-1:0];
        REG_MODE:   cmode_r  <= pwdata[0];
        REG_CLIM:   clim_r   <= pwdata[LIM_W-1:0];
        REG_MLIM:   mlim_r   <= pwdata[LIM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_MODE:   prdata = 32'(cmode_r);
      REG_CLIM:   prdata = 32'(clim_r);
      REG_MLIM:   prdata = 32'(mlim_r);
      default:    prdata = '0;
    endcase
  end

  // zero sizes act as one, widths beyond the line store are capped
  assign eff_w = (width_r == '0) ? COL_W'(1) :
                 ((int'(width_r) > W_CAP) ? COL_W'(W_CAP) : width_r);
  assign eff_h = (height_r == '0) ? ROW_W'(1) : height_r;

  logic acc;
  logic clearing;
  cmd_t cmd_in;
  logic cmd_push;
  cmd_t cmd_head;
  logic q_empty;
  logic q_full;
  logic q_pop;

  assign full = q_full || clearing;
  assign acc  = push && !full;

  lmb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .WIN_W     (WIN_W),
    .WIN_H     (WIN_H)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_pos_i  (size_wr),
    .eff_w_i    (eff_w),
    .eff_h_i    (eff_h),
    .acc_i      (acc),
    .mode_i     (in_mode),
    .pixel_i    (in_pixel),
    .cmd_o      (cmd_in),
    .cmd_push_o (cmd_push)
  );

  lmb_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (q_pop),
    .data_o  (cmd_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lmb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .WIN_W     (WIN_W),
    .WIN_H     (WIN_H)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clearing_o       (clearing),
    .q_empty_i        (q_empty),
    .q_head_i         (cmd_head),
    .q_pop_o          (q_pop),
    .contrast_mode_i  (cmode_r),
    .contrast_limit_i (clim_r),
    .mean_limit_i     (mlim_r),
    .out_empty_o      (empty),
    .out_pop_i        (pop),
    .out_bit_o        (out_binary_pixel),
    .out_last_o       (out_frame_last)
  );

endmodule

`default_nettype wire

FILE: sim/local_minmax_window_binarizer_tb.sv
// self-checking testbench of the local min/max window binarizer
`timescale 1ns / 1ps

module local_minmax_window_binarizer_tb;
  import lmb_pkg::*;

  localparam int MAX_WIDTH = 1024;
  localparam int WIN_W = 5;
  localparam int WIN_H = 5;
  localparam int SLOTS = WIN_H + 1;
  localparam int HALF_W = WIN_W / 2;
  localparam int HALF_H = WIN_H / 2;
  localparam int SETTLE = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT_CYCLES = 1000000;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam int REG_WIDTH = 0;
  localparam int REG_HEIGHT = 1;
  localparam int REG_MODE = 2;
  localparam int REG_CLIM = 3;
  localparam int REG_MLIM = 4;

  typedef struct packed {
    logic binary_pixel;
    logic frame_last;
  } bin_result_t;

  typedef enum int {TEX_UNIFORM, TEX_NARROW, TEX_BINARY, TEX_FLAT} texture_e;

  logic clk;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic in_mode = 1'b0;
  logic [PIX_W-1:0] in_pixel = '0;
  logic pop = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic full, empty, out_binary_pixel, out_frame_last, pready;
  logic [31:0] prdata;

  local_minmax_window_binarizer #(
    .MAX_WIDTH(MAX_WIDTH),
    .WIN_W(WIN_W),
    .WIN_H(WIN_H)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_mode(in_mode),
    .in_pixel(in_pixel),
    .empty(empty),
    .pop(pop),
    .out_binary_pixel(out_binary_pixel),
    .out_frame_last(out_frame_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // raster model of the block
  logic [7:0] line_model [0:SLOTS-1][0:MAX_WIDTH-1];
  int unsigned px_col, px_row, px_pending, rel_col, rel_row, wr_slot, rd_slot;
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic mode_reg;
  logic [7:0] clim_reg, mlim_reg;
  bin_result_t binarized_q [$];

  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  texture_e tex_style = TEX_UNIFORM;
  int tex_base = 0;
  int tex_spread = 0;
  bin_result_t head;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still due", $time, binarized_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random idling plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (binarized_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual binary_pixel=%0b frame_last=%0b",
                 $time, out_binary_pixel, out_frame_last);
        error_count++;
      end else begin
        head = binarized_q.pop_front();
        results_checked++;
        if (out_binary_pixel !== head.binary_pixel) begin
          $display("%0t: binary_pixel mismatch, expected %0b, actual %0b",
                   $time, head.binary_pixel, out_binary_pixel);
          error_count++;
        end
        if (out_frame_last !== head.frame_last) begin
          $display("%0t: frame_last mismatch, expected %0b, actual %0b",
                   $time, head.frame_last, out_frame_last);
          error_count++;
        end
      end
    end
  end

  function automatic int unsigned act_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned act_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic [31:0] reg_mask(input int idx);
    case (idx)
      REG_WIDTH:  return 32'h7FF;
      REG_HEIGHT: return 32'hFFFF;
      REG_MODE:   return 32'h1;
      default:    return 32'hFF;
    endcase
  endfunction

  task automatic clear_raster();
    px_col = 0;
    px_row = 0;
    px_pending = 0;
    rel_col = 0;
    rel_row = 0;
    wr_slot = 0;
    rd_slot = 0;
  endtask

  task automatic reset_model();
    for (int s = 0; s < SLOTS; s++) begin
      for (int c = 0; c < MAX_WIDTH; c++) line_model[s][c] = '0;
    end
    clear_raster();
    width_reg = 11'd640;
    height_reg = 16'd480;
    mode_reg = 1'b0;
    clim_reg = 8'd15;
    mlim_reg = 8'd127;
  endtask

  task automatic apply_register(input int idx, input logic [31:0] value);
    case (idx)
      REG_WIDTH: begin
        width_reg = value[10:0];
        clear_raster();
      end
      REG_HEIGHT: begin
        height_reg = value[15:0];
        clear_raster();
      end
      REG_MODE: mode_reg = value[0];
      REG_CLIM: clim_reg = value[7:0];
      REG_MLIM: mlim_reg = value[7:0];
      default: ;
    endcase
  endtask

  // window max/min at the release position, then the threshold decision
  task automatic release_result();
    int unsigned w, h, mid, contrast, own, mx, mn, c0, s, v;
    bin_result_t r;
    w = act_width();
    h = act_height();
    mid = 0;
    contrast = 0;
    own = line_model[rd_slot][rel_col];
    if (rel_row >= HALF_H && rel_row + HALF_H < h &&
        rel_col >= HALF_W && rel_col + HALF_W < w) begin
      mx = 0;
      mn = 255;
      c0 = rel_col - HALF_W;
      for (int k = 0; k < WIN_H; k++) begin
        s = (rd_slot + SLOTS - HALF_H + k) % SLOTS;
        for (int c = 0; c < WIN_W; c++) begin
          v = line_model[s][(c0 + c) % MAX_WIDTH];
          if (v > mx) mx = v;
          if (v < mn) mn = v;
        end
      end
      mid = (mx + mn) >> 1;
      contrast = mx - mn;
    end
    if (!mode_reg) r.binary_pixel = (own > mid);
    else if (contrast > clim_reg) r.binary_pixel = 1'b1;
    else if (contrast < clim_reg) r.binary_pixel = (mid > mlim_reg);
    else r.binary_pixel = 1'b0;
    r.frame_last = (rel_row == h - 1 && rel_col == w - 1);
    binarized_q.push_back(r);
    px_pending--;
    rel_col++;
    if (rel_col >= w) begin
      rel_col = 0;
      rd_slot = (rd_slot + 1) % SLOTS;
      rel_row++;
      if (rel_row >= h) rel_row = 0;
    end
  endtask

  task automatic binarize_word(input logic m, input logic [7:0] p);
    int unsigned w, h, lag;
    w = act_width();
    h = act_height();
    lag = HALF_H * w + HALF_W;
    words_sent++;
    if (m == MODE_PIXEL) begin
      line_model[wr_slot][px_col] = p;
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        wr_slot = (wr_slot + 1) % SLOTS;
        px_row++;
        if (px_row >= h) px_row = 0;
      end
      px_pending++;
      if (px_pending > lag) release_result();
    end else if (px_pending != 0) begin
      release_result();
    end
  endtask

  task automatic send_word(input logic m, input logic [7:0] p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_mode <= m;
    in_pixel <= p;
    do @(posedge clk); while (full);
    binarize_word(m, p);
  endtask

  // wait for every due result, then let in-flight words settle
  task automatic drain(input int settle);
    push <= 1'b0;
    while (binarized_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic check_reg(input int idx, input logic [31:0] want);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 5'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
               $time, idx, want, got);
      error_count++;
    end
  endtask

  task automatic write_reg(input int idx, input logic [31:0] value);
    push <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_register(idx, value);
    reg_writes++;
    @(posedge clk);
    check_reg(idx, value & reg_mask(idx));
  endtask

  task automatic configure(input int w, input int h, input int m, input int cl, input int ml);
    drain(SETTLE);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, m);
    write_reg(REG_CLIM, cl);
    write_reg(REG_MLIM, ml);
  endtask

  task automatic flush_pending();
    while (px_pending != 0) send_word(MODE_FLUSH, $urandom_range(0, 255));
  endtask

  function automatic int pick_limit(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return 255;
    return $urandom_range(lo, hi);
  endfunction

  task automatic set_texture();
    tex_style = texture_e'($urandom_range(0, 3));
    tex_base = $urandom_range(0, 255);
    tex_spread = $urandom_range(0, clim_reg + 3);
  endtask

  function automatic logic [7:0] next_pixel();
    int v;
    case (tex_style)
      TEX_UNIFORM: v = $urandom_range(0, 255);
      TEX_NARROW:  v = tex_base + $urandom_range(0, tex_spread);
      TEX_BINARY:  v = $urandom_range(0, 1) ? 255 : 0;
      default:     v = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : tex_base;
    endcase
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic test_reset_regs();
    check_reg(REG_WIDTH, 32'd640);
    check_reg(REG_HEIGHT, 32'd480);
    check_reg(REG_MODE, 32'd0);
    check_reg(REG_CLIM, 32'd15);
    check_reg(REG_MLIM, 32'd127);
  endtask

  // one 5x5 frame: only the center has a full window, then early flushes
  task automatic test_small_frame();
    logic [7:0] p;
    configure(5, 5, 0, 15, 127);
    for (int i = 0; i < 25; i++) begin
      if (i == 12) p = 8'd200;
      else if (i % 3 == 0) p = 8'h00;
      else if (i % 3 == 1) p = 8'hFF;
      else p = 8'h01;
      send_word(MODE_PIXEL, p);
    end
    send_word(MODE_FLUSH, 8'hFF);
    send_word(MODE_FLUSH, 8'h00);
  endtask

  // one-pixel frames; the size write also drops what the last test left
  task automatic test_tiny_frame();
    configure(1, 1, 0, 15, 127);
    send_word(MODE_FLUSH, 8'hA5);
    send_word(MODE_PIXEL, 8'hFF);
    send_word(MODE_FLUSH, 8'h00);
    send_word(MODE_PIXEL, 8'h00);
    send_word(MODE_FLUSH, 8'hFF);
    configure(1, 1, 1, 0, 0);
    send_word(MODE_PIXEL, 8'hFF);
    send_word(MODE_FLUSH, 8'h5A);
  endtask

  task automatic test_random_frames(input int target);
    int done_px, w, h, n, r;
    done_px = 0;
    while (done_px < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        w = $urandom_range(5, 10);
        h = $urandom_range(5, 7);
      end else if (r < 80) begin
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 6);
      end else if (r < 92) begin
        w = $urandom_range(5, 9);
        h = $urandom_range(1, 4);
      end else begin
        w = $urandom_range(11, 40);
        h = $urandom_range(5, 6);
      end
      configure(w, h, $urandom_range(0, 1), pick_limit(0, 60), pick_limit(60, 190));
      set_texture();
      n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
      if (n > 300) n = 300;
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        // stray flush releases a result early, from whatever the rows hold
        if (r < 4) send_word(MODE_FLUSH, $urandom_range(0, 255));
        else if (r < 6) drain(0);
        send_word(MODE_PIXEL, next_pixel());
      end
      done_px += n;
      r = $urandom_range(0, 99);
      if (r < 80) flush_pending();
      if (r < 10 || (r >= 80 && r < 85)) begin
        repeat ($urandom_range(1, 3)) send_word(MODE_FLUSH, $urandom_range(0, 255));
      end
    end
  endtask

  task automatic test_backpressure();
    configure(6, 8, 0, 15, 127);
    set_texture();
    repeat (30) send_word(MODE_PIXEL, next_pixel());
    hold_seq <= hold_seq + 1;
    repeat (120) send_word(MODE_PIXEL, next_pixel());
    drain(0);
    repeat (40) send_word(MODE_PIXEL, next_pixel());
    flush_pending();
  endtask

  task automatic test_limit_extremes();
    int cl, ml;
    for (int i = 0; i < 4; i++) begin
      cl = (i & 1) ? 255 : 0;
      ml = (i & 2) ? 255 : 0;
      configure(6, 6, 1, cl, ml);
      set_texture();
      repeat (36) send_word(MODE_PIXEL, next_pixel());
      flush_pending();
    end
  endtask

  task automatic test_wide_rows();
    configure(MAX_WIDTH, 5, 0, 15, 127);
    tex_style = TEX_UNIFORM;
    repeat (MAX_WIDTH * 5) send_word(MODE_PIXEL, next_pixel());
    flush_pending();
  endtask

  task automatic test_tall_frame();
    configure(7, 65535, 1, pick_limit(0, 40), pick_limit(60, 190));
    set_texture();
    repeat (49) send_word(MODE_PIXEL, next_pixel());
    flush_pending();
  endtask

  initial begin
    reset_model();
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_regs();
    // line store clear after reset keeps full high
    while (full) @(posedge clk);
    test_small_frame();
    test_tiny_frame();

    send_idle_pct = 28;
    recv_idle_pct <= 66;
    test_random_frames(500);

    send_idle_pct = 66;
    recv_idle_pct <= 28;
    test_random_frames(500);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_backpressure();
    test_limit_extremes();
    test_tall_frame();
    test_wide_rows();
    test_random_frames(500);

    drain(4 * SETTLE);
    $display("covered %0d words, %0d results checked, %0d register writes",
             words_sent, results_checked, reg_writes);
    $display("frame sizes from 1x1 to %0dx5 and height 65535, both modes, limit extremes",
             MAX_WIDTH);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lmb_pkg.sv
rtl/lmb_front.sv
rtl/lmb_cmdq.sv
rtl/lmb_back.sv
rtl/local_minmax_window_binarizer.sv
sim/local_minmax_window_binarizer_tb.sv
